// File: hw/rtl/gtsa_pkg.sv
package gtsa_pkg;

    localparam int SLOT_COUNT = 1024;

    localparam int IDX_W     = $clog2(SLOT_COUNT);
    localparam int CNT_W     = $clog2(SLOT_COUNT + 1);
    localparam int GEN_W     = 32;
    localparam int REQ_IDX_W = 16;
    localparam int OUT_IDX_W = 12;
    localparam int USED_W    = 13;
    localparam int OP_W      = 2;

    // occupancy bitmap geometry
    localparam int WORD_W   = 32;
    localparam int BIT_W    = $clog2(WORD_W);
    localparam int WORD_CNT = (SLOT_COUNT + WORD_W - 1) / WORD_W;
    localparam int WSEL_W   = (WORD_CNT > 1) ? $clog2(WORD_CNT) : 1;

    // request codes
    localparam logic [OP_W-1:0] OP_ALLOC  = 2'd0;
    localparam logic [OP_W-1:0] OP_FREE   = 2'd1;
    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_INVALID = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_FIND
    } t_state;

    typedef struct packed {
        logic find_word;   // latch the first word with a free slot
        logic use_search;  // read port follows the search word
        logic set;         // mark slot occupied
        logic clr;         // mark slot free
    } t_map_ctl;

endpackage

// File: hw/rtl/generation_tagged_slot_allocator.sv
// Generational handle allocator over SLOT_COUNT slots. Each request (allocate, free or
// look up) gives exactly one result transaction. A request is accepted in S_IDLE; S_CHECK
// then checks the request and starts the lookup (generation memory read, first
// non-full bitmap word), and S_FIND finishes the search inside the selected bitmap
// word, commits the update and loads the result register, which offers the result
// transaction. The next request can be accepted only after S_FIND returns to S_IDLE,
// so a new request is not taken before the last one has loaded its result.
// The next request is accepted while the result still waits on the master side; it then
// holds in its search cycle until that result is taken.
// Generations live in a single-port synchronous RAM; a per-slot occupancy bitmap in
// flip-flops marks which RAM entries are live, so no clearing pass is needed after
// reset and the block is ready as soon as reset is released. A freed
// slot only loses its bitmap bit; its RAM entry is rewritten when it is next allocated.
module generation_tagged_slot_allocator
    import gtsa_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // req_generation[31:0], req_index[47:32]
    input  logic [1:0]  s_axis_tuser,   // op[1:0]

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // out_generation[31:0], out_index[43:32],
                                        // used_count[56:44], zero fill[63:57]
    output logic [1:0]  m_axis_tuser    // status[1:0]
);

    t_state r_state;
    t_state n_state;

    // request being worked on
    logic [OP_W-1:0]      r_op;
    logic [GEN_W-1:0]     r_gen;
    logic [REQ_IDX_W-1:0] r_idx;

    // early verdict from the check cycle
    logic    r_fail;
    t_status r_fail_status;

    logic [CNT_W-1:0] r_count;
    logic [GEN_W-1:0] r_next_gen;

    // result register
    logic                 r_m_valid;
    t_status              r_m_status;
    logic [GEN_W-1:0]     r_m_gen;
    logic [OUT_IDX_W-1:0] r_m_idx;
    logic [USED_W-1:0]    r_m_used;

    logic             in_range;
    logic [IDX_W-1:0] idx_slot;
    logic             out_free;
    logic             fire;

    t_map_ctl         map_ctl;
    logic [IDX_W-1:0] free_slot;
    logic             map_used;
    logic [IDX_W-1:0] upd_index;

    logic             ram_we;
    logic             ram_re;
    logic [IDX_W-1:0] ram_addr;
    logic [GEN_W-1:0] ram_rdata;

    logic             chk_fail;
    t_status          chk_status;

    t_status          res_status;
    logic [GEN_W-1:0] res_gen;
    logic [OUT_IDX_W-1:0] res_idx;
    logic [CNT_W-1:0] res_count;
    logic [GEN_W-1:0] gen_inc;

    assign in_range = (r_idx < REQ_IDX_W'(SLOT_COUNT));
    assign idx_slot = IDX_W'(r_idx);
    assign out_free = !r_m_valid || m_axis_tready;
    assign fire     = (r_state == S_FIND) && out_free;
    assign gen_inc  = r_next_gen + GEN_W'(1);

    // ---------------------------------------------------------------- next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (s_axis_tvalid) n_state = S_CHECK;
            S_CHECK: n_state = S_FIND;
            S_FIND:  if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // ---------------------------------------------------------------- control outputs
    always_comb begin
        s_axis_tready = 1'b0;
        map_ctl       = '0;
        ram_re        = 1'b0;
        ram_we        = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                s_axis_tready = 1'b1;
            end
            S_CHECK: begin
                map_ctl.find_word = (r_op == OP_ALLOC);
                ram_re            = (r_op == OP_LOOKUP) && in_range;
            end
            S_FIND: begin
                map_ctl.use_search = (r_op == OP_ALLOC);
                map_ctl.set        = fire && !r_fail && (r_op == OP_ALLOC);
                map_ctl.clr        = fire && !r_fail && (r_op == OP_FREE) && map_used;
                ram_we             = fire && !r_fail && (r_op == OP_ALLOC);
            end
            default: begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    assign upd_index = (r_op == OP_ALLOC) ? free_slot : idx_slot;
    assign ram_addr  = ram_we ? free_slot : idx_slot;

    // ---------------------------------------------------------------- check cycle verdict
    always_comb begin
        chk_fail   = 1'b0;
        chk_status = ST_OK;
        priority if (r_op == OP_ALLOC) begin
            chk_fail   = (r_count == CNT_W'(SLOT_COUNT));
            chk_status = ST_FULL;
        end else if (r_op == OP_FREE) begin
            chk_fail   = !in_range;
            chk_status = ST_INVALID;
        end else if (r_op == OP_LOOKUP) begin
            chk_fail   = !in_range || (r_gen == '0);
            chk_status = ST_INVALID;
        end else begin
            chk_fail   = 1'b1;    // unused request code
            chk_status = ST_INVALID;
        end
    end

    // ---------------------------------------------------------------- result
    always_comb begin
        res_status = ST_OK;
        res_gen    = '0;
        res_idx    = '0;
        res_count  = r_count;
        priority if (r_fail) begin
            res_status = r_fail_status;
        end else if (r_op == OP_ALLOC) begin
            res_gen   = r_next_gen;
            res_idx   = OUT_IDX_W'(free_slot);
            res_count = r_count + CNT_W'(1);
        end else if (r_op == OP_FREE) begin
            res_idx = OUT_IDX_W'(r_idx);
            if (map_used) begin
                res_count = r_count - CNT_W'(1);
            end
        end else if (map_used && (ram_rdata == r_gen)) begin
            res_gen = r_gen;
            res_idx = OUT_IDX_W'(r_idx);
        end else begin
            res_status = ST_INVALID;   // stale or never-issued handle
        end
    end

    // ---------------------------------------------------------------- registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_count    <= '0;
            r_next_gen <= GEN_W'(1);
            r_m_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (fire) begin
                r_count   <= res_count;
                r_m_valid <= 1'b1;
                if (!r_fail && (r_op == OP_ALLOC)) begin
                    // generation zero means free, so the counter skips it
                    r_next_gen <= (gen_inc == '0) ? GEN_W'(1) : gen_inc;
                end
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_gen <= s_axis_tdata[31:0];
            r_idx <= s_axis_tdata[47:32];
            r_op  <= s_axis_tuser;
        end
        if (r_state == S_CHECK) begin
            r_fail        <= chk_fail;
            r_fail_status <= chk_status;
        end
        if (fire) begin
            r_m_status <= res_status;
            r_m_gen    <= res_gen;
            r_m_idx    <= res_idx;
            r_m_used   <= USED_W'(res_count);
        end
    end

    // ---------------------------------------------------------------- storage
    gtsa_free_map u_free_map (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (map_ctl),
        .i_query_index (idx_slot),
        .i_upd_index   (upd_index),
        .o_free_slot   (free_slot),
        .o_query_used  (map_used)
    );

    gtsa_ram #(
        .DEPTH  (SLOT_COUNT),
        .WIDTH  (GEN_W),
        .ADDR_W (IDX_W)
    ) u_gen_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_re    (ram_re),
        .i_addr  (ram_addr),
        .i_wdata (r_next_gen),
        .o_rdata (ram_rdata)
    );

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {7'b0, r_m_used, r_m_idx, r_m_gen};
    assign m_axis_tuser  = r_m_status;

    // ---------------------------------------------------------------- assertions
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(SLOT_COUNT))
        else $error("slot count above table size");

    a_gen_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_next_gen != '0)
        else $error("generation counter reached zero");

    a_free_decrements: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && !r_fail && (r_op == OP_FREE) && map_used)
        |=> (r_count == $past(r_count) - CNT_W'(1)))
        else $error("free of live slot did not drop the count");

    a_alloc_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && !r_fail && (r_op == OP_ALLOC))
        |=> (r_m_valid && (r_m_gen != '0) && (r_m_used != '0)))
        else $error("allocation result carries zero generation or count");

endmodule

// File: hw/rtl/gtsa_ram.sv
module gtsa_ram #(
    parameter int DEPTH  = 1024,
    parameter int WIDTH  = 32,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_addr,
    input  logic [WIDTH-1:0]  i_wdata,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/gtsa_free_map.sv
module gtsa_free_map
    import gtsa_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_map_ctl         i_ctl,
    input  logic [IDX_W-1:0] i_query_index,
    input  logic [IDX_W-1:0] i_upd_index,
    output logic [IDX_W-1:0] o_free_slot,
    output logic             o_query_used
);

    logic [WORD_W-1:0] r_map [WORD_CNT];
    logic [WSEL_W-1:0] r_word_sel;
    logic [WSEL_W-1:0] n_word_sel;
    logic [WSEL_W-1:0] rd_word;
    logic [WORD_W-1:0] rd_data;
    logic [BIT_W-1:0]  free_bit;
    logic [WSEL_W-1:0] upd_word;
    logic [BIT_W-1:0]  upd_bit;

    // slots past the end of the table read as permanently occupied
    function automatic logic [WORD_W-1:0] pad_word(input int w);
        logic [WORD_W-1:0] m;
        m = '0;
        for (int b = 0; b < WORD_W; b++) begin
            m[b] = ((w * WORD_W + b) >= SLOT_COUNT);
        end
        return m;
    endfunction

    // first word that is not completely occupied
    always_comb begin
        n_word_sel = '0;
        for (int w = WORD_CNT - 1; w >= 0; w--) begin
            if (!(&r_map[w])) begin
                n_word_sel = WSEL_W'(w);
            end
        end
    end

    assign rd_word = i_ctl.use_search ? r_word_sel : WSEL_W'(i_query_index >> BIT_W);
    assign rd_data = r_map[rd_word];

    // first free bit inside the selected word
    always_comb begin
        free_bit = '0;
        for (int b = WORD_W - 1; b >= 0; b--) begin
            if (!rd_data[b]) begin
                free_bit = BIT_W'(b);
            end
        end
    end

    assign o_free_slot  = IDX_W'({r_word_sel, free_bit});
    assign o_query_used = rd_data[BIT_W'(i_query_index)];

    assign upd_word = WSEL_W'(i_upd_index >> BIT_W);
    assign upd_bit  = BIT_W'(i_upd_index);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int w = 0; w < WORD_CNT; w++) begin
                r_map[w] <= pad_word(w);
            end
        end else if (i_ctl.set) begin
            r_map[upd_word][upd_bit] <= 1'b1;
        end else if (i_ctl.clr) begin
            r_map[upd_word][upd_bit] <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.find_word) begin
            r_word_sel <= n_word_sel;
        end
    end

endmodule

// File: sim/testbench.sv
module testbench
    import gtsa_pkg::*;
();

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    localparam int RANDOM_ITEMS   = 100;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int LONG_HOLD      = 300;

    // one result transaction, split into its fields
    typedef struct packed {
        t_status              status;
        logic [GEN_W-1:0]     gen;
        logic [OUT_IDX_W-1:0] idx;
        logic [USED_W-1:0]    used;
    } t_reply;

    logic        i_clk;
    logic        i_rst_n;

    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;   // req_generation[31:0], req_index[47:32]
    logic [1:0]  s_axis_tuser;   // op[1:0]

    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;   // out_generation[31:0], out_index[43:32],
                                 // used_count[56:44], zero fill[63:57]
    logic [1:0]  m_axis_tuser;   // status[1:0]

    // handle table as the block should hold it
    logic [GEN_W-1:0] slot_gen_mirror [SLOT_COUNT];
    logic [GEN_W-1:0] gen_counter;
    int               live_count;
    int               high_water;

    t_reply replies_due [$];
    t_reply reply_got;
    t_reply reply_want;

    int mismatches        = 0;
    int idle_cycles       = 0;
    bit src_steady        = 1'b0;
    bit sink_steady       = 1'b0;
    int sink_hold_request = 0;

    generation_tagged_slot_allocator uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 80) return $urandom_range(1, 3);
        if (roll < 95) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // applies one request to the mirrored table and returns the reply it must give
    function automatic t_reply compute_handle_reply(input logic [OP_W-1:0] op,
                                                    input logic [GEN_W-1:0] req_gen,
                                                    input logic [REQ_IDX_W-1:0] req_idx);
        t_reply r;
        int     slot;
        r        = '0;
        r.status = ST_INVALID;
        slot     = -1;
        case (op)
            OP_ALLOC: begin
                // lowest free slot, no search at all when the count says full
                if (live_count < SLOT_COUNT) begin
                    for (int i = 0; i < SLOT_COUNT; i++) begin
                        if (slot < 0 && slot_gen_mirror[i] == '0) slot = i;
                    end
                end
                if (slot < 0) begin
                    r.status = ST_FULL;
                end else begin
                    slot_gen_mirror[slot] = gen_counter;
                    live_count++;
                    if (slot >= high_water) high_water = slot + 1;
                    r.status = ST_OK;
                    r.gen    = gen_counter;
                    r.idx    = OUT_IDX_W'(slot);
                    // generation zero means free, so the counter skips it on wrap
                    gen_counter = (gen_counter == '1) ? GEN_W'(1) : gen_counter + 1'b1;
                end
            end
            OP_FREE: begin
                if (req_idx < SLOT_COUNT) begin
                    // freeing a free slot leaves the count alone
                    if (slot_gen_mirror[req_idx] != '0) begin
                        slot_gen_mirror[req_idx] = '0;
                        if (live_count > 0) live_count--;
                    end
                    r.status = ST_OK;
                    r.idx    = req_idx[OUT_IDX_W-1:0];
                end
            end
            OP_LOOKUP: begin
                // generation zero never matches, not even a free slot
                if (req_idx < SLOT_COUNT && req_gen != '0 &&
                    slot_gen_mirror[req_idx] == req_gen) begin
                    r.status = ST_OK;
                    r.gen    = req_gen;
                    r.idx    = req_idx[OUT_IDX_W-1:0];
                end
            end
            default: ;
        endcase
        r.used = USED_W'(live_count);
        return r;
    endfunction

    // some slot that holds a live handle, or -1
    function automatic int pick_live_slot();
        int slot;
        if (live_count == 0) return -1;
        for (int t = 0; t < 64; t++) begin
            slot = $urandom_range(0, high_water - 1);
            if (slot_gen_mirror[slot] != '0) return slot;
        end
        return -1;
    endfunction

    // drives one request at the falling edge and holds it until accepted
    task automatic send_request(input logic [OP_W-1:0] op,
                                input logic [GEN_W-1:0] req_gen,
                                input logic [REQ_IDX_W-1:0] req_idx);
        int gap;
        gap = (src_steady || $urandom_range(0, 2) != 0) ? 0 : pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {req_idx, req_gen};
        s_axis_tuser  <= op;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        replies_due.push_back(compute_handle_reply(op, req_gen, req_idx));
    endtask

    // mostly well-formed handles, the rest stale, zero, out of range or unused codes
    task automatic send_random_request();
        int               roll;
        int               slot;
        logic [OP_W-1:0]  op;
        logic [GEN_W-1:0] g;
        logic [REQ_IDX_W-1:0] ix;
        roll = $urandom_range(0, 99);
        g    = $urandom;
        ix   = REQ_IDX_W'($urandom);
        slot = pick_live_slot();
        if (roll < 35) begin
            op = OP_ALLOC;
        end else if (roll < 60) begin
            op = OP_FREE;
            if (slot >= 0 && $urandom_range(0, 4) != 0) begin
                ix = REQ_IDX_W'(slot);
            end else if ($urandom_range(0, 1) == 0) begin
                ix = REQ_IDX_W'($urandom_range(0, SLOT_COUNT - 1));
            end
        end else if (roll < 95) begin
            op = OP_LOOKUP;
            case ($urandom_range(0, 9))
                0: begin
                    g  = '0;
                    ix = REQ_IDX_W'($urandom_range(0, SLOT_COUNT - 1));
                end
                1: ;
                2: begin
                    if (slot >= 0) begin
                        ix = REQ_IDX_W'(slot);
                        g  = slot_gen_mirror[slot] ^ (GEN_W'(1) << $urandom_range(0, 31));
                    end
                end
                default: begin
                    if (slot >= 0) begin
                        ix = REQ_IDX_W'(slot);
                        g  = slot_gen_mirror[slot];
                    end
                end
            endcase
        end else begin
            op = OP_UNUSED;
        end
        send_request(op, g, ix);
    endtask

    task automatic test_directed_cases();
        send_request(OP_LOOKUP, '0, '0);                       // zero generation, empty table
        send_request(OP_ALLOC, '1, '1);                        // slot 0, generation 1
        send_request(OP_ALLOC, '0, '0);                        // slot 1, generation 2
        send_request(OP_ALLOC, '1, '0);                        // slot 2, generation 3
        send_request(OP_LOOKUP, GEN_W'(2), REQ_IDX_W'(1));     // live handle
        send_request(OP_LOOKUP, '0, REQ_IDX_W'(1));            // zero generation, live slot
        send_request(OP_LOOKUP, '0, REQ_IDX_W'(5));            // zero generation, free slot
        send_request(OP_LOOKUP, GEN_W'(3), REQ_IDX_W'(1));     // generation mismatch
        send_request(OP_LOOKUP, GEN_W'(1), REQ_IDX_W'(SLOT_COUNT));
        send_request(OP_LOOKUP, '1, '1);
        send_request(OP_FREE, '1, REQ_IDX_W'(1));
        send_request(OP_FREE, '0, REQ_IDX_W'(1));              // already free
        send_request(OP_LOOKUP, GEN_W'(2), REQ_IDX_W'(1));     // stale handle
        send_request(OP_ALLOC, '0, '1);                        // reuses slot 1
        send_request(OP_FREE, '0, REQ_IDX_W'(SLOT_COUNT));     // out of range
        send_request(OP_FREE, '1, '1);
        send_request(OP_FREE, '0, REQ_IDX_W'(SLOT_COUNT - 1)); // top slot, free
        send_request(OP_UNUSED, '1, '1);
        send_request(OP_UNUSED, '0, '0);
        send_request(OP_LOOKUP, '1, REQ_IDX_W'(SLOT_COUNT - 1));
        send_request(OP_FREE, '0, REQ_IDX_W'(0));
        send_request(OP_FREE, '0, REQ_IDX_W'(1));
        send_request(OP_FREE, '0, REQ_IDX_W'(2));
        send_request(OP_ALLOC, '0, '0);                        // empty again, slot 0
    endtask

    // steady and gappy stretches are picked at random on both sides
    task automatic test_random_mix();
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 50 == 0) begin
                src_steady  = ($urandom_range(0, 3) == 0);
                sink_steady = ($urandom_range(0, 3) == 0);
            end
            send_random_request();
        end
        src_steady  = 1'b0;
        sink_steady = 1'b0;
    endtask

    // receiver holds off long enough for the block to back up onto its input
    task automatic test_output_stall();
        src_steady        = 1'b1;
        sink_hold_request = LONG_HOLD;
        for (int n = 0; n < 24; n++) send_random_request();
        src_steady = 1'b0;
    endtask

    // generation wrap would take 2^32 allocations and is out of reach here
    task automatic test_pool_full();
        int slot;
        while (live_count < SLOT_COUNT) send_request(OP_ALLOC, $urandom, REQ_IDX_W'($urandom));
        repeat (3) send_request(OP_ALLOC, $urandom, REQ_IDX_W'($urandom));
        slot = SLOT_COUNT - 1;
        send_request(OP_LOOKUP, slot_gen_mirror[slot], REQ_IDX_W'(slot));
        send_request(OP_FREE, '0, REQ_IDX_W'(slot));
        send_request(OP_ALLOC, '0, '0);                        // refills the top slot
        send_request(OP_ALLOC, '0, '0);                        // full again
        // churn near the top of the pool
        repeat (30) send_random_request();
    endtask

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        for (int i = 0; i < SLOT_COUNT; i++) slot_gen_mirror[i] = '0;
        gen_counter = GEN_W'(1);
        live_count  = 0;
        high_water  = 0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_cases();
        test_random_mix();
        test_output_stall();
        test_pool_full();

        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (replies_due.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // result side ready, with random stalls and the occasional long hold
    initial begin : result_sink
        int stall_left;
        stall_left    = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_left == 0) begin
                if (sink_hold_request > 0) begin
                    stall_left        = sink_hold_request;
                    sink_hold_request = 0;
                end else if (!sink_steady && $urandom_range(0, 3) == 0) begin
                    stall_left = pick_gap();
                end
            end
            if (stall_left > 0) begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t: %s expected %0h got %0h", $time, field, want, got);
        end
    endtask

    // every result transaction against the oldest reply due
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            reply_got.status = t_status'(m_axis_tuser);
            reply_got.gen    = m_axis_tdata[31:0];
            reply_got.idx    = m_axis_tdata[43:32];
            reply_got.used   = m_axis_tdata[56:44];
            if (replies_due.size() == 0) begin
                mismatches++;
                $display("%0t: result expected none got %0h", $time, reply_got);
            end else begin
                reply_want = replies_due.pop_front();
                check_field("status", 32'(reply_want.status), 32'(reply_got.status));
                check_field("out_generation", reply_want.gen, reply_got.gen);
                check_field("out_index", 32'(reply_want.idx), 32'(reply_got.idx));
                check_field("used_count", 32'(reply_want.used), 32'(reply_got.used));
            end
        end
    end

    // ends a run that stops moving
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

endmodule
